@@ rtl/jet_pkg.sv @@
// Shared types and constants for the Julia escape-time core.
`timescale 1ns / 1ps
`default_nettype none

package jet_pkg;

    localparam int COORD_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

    localparam logic [COUNT_W-1:0] ITER_LIMIT_RESET = 16'd512;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_step;
        logic signed [COORD_W-1:0] x_origin;
        logic signed [COORD_W-1:0] y_step;
        logic signed [COORD_W-1:0] y_origin;
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
        logic [COUNT_W-1:0]        iteration_limit;
    } jet_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] zx;
        logic signed [COORD_W-1:0] zy;
    } jet_point_t;

endpackage

`default_nettype wire

@@ rtl/jet_front.sv @@
// Front end: accepts pixel beats and forms the start point of the orbit.
`timescale 1ns / 1ps
`default_nettype none

module jet_front import jet_pkg::*; #(
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIXEL_BITS-1:0] column,
    input  wire logic [PIXEL_BITS-1:0] row,
    input  wire jet_cfg_t              cfg,
    output logic                       push,
    output jet_point_t                 push_point,
    input  wire logic                  full
);

    localparam int PROD_W = PIXEL_BITS + COORD_W;

    logic                valid_reg;
    logic                valid_next;
    logic [COORD_W-1:0]  x_prod_reg;
    logic [COORD_W-1:0]  y_prod_reg;
    logic [PROD_W-1:0]   x_prod_full;
    logic [PROD_W-1:0]   y_prod_full;
    logic                accept;

    // low word of index * step is the same for signed and unsigned step
    assign x_prod_full = {{COORD_W{1'b0}}, column} * {{PIXEL_BITS{1'b0}}, cfg.x_step};
    assign y_prod_full = {{COORD_W{1'b0}}, row} * {{PIXEL_BITS{1'b0}}, cfg.y_step};

    assign in_stall      = valid_reg && full;
    assign accept        = in_valid && !in_stall;
    assign push          = valid_reg;
    assign push_point.zx = x_prod_reg - cfg.x_origin;
    assign push_point.zy = y_prod_reg - cfg.y_origin;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_prod_reg <= x_prod_full[COORD_W-1:0];
            y_prod_reg <= y_prod_full[COORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/jet_queue.sv @@
// Short queue of start points between front end and iteration engine.
`timescale 1ns / 1ps
`default_nettype none

module jet_queue import jet_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire jet_point_t push_point,
    output logic            full,
    input  wire logic       pop,
    output jet_point_t      head,
    output logic            empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jet_point_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_point;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jet_back.sv @@
// Iteration engine: runs z = z^2 + c until escape or limit, holds the result beat.
`timescale 1ns / 1ps
`default_nettype none

module jet_back import jet_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire jet_cfg_t   cfg,
    input  wire logic       empty,
    input  wire jet_point_t head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [COUNT_W-1:0] escape_count
);

    localparam int PROD_W          = 2 * COORD_W;
    localparam bit BOUND_FITS      = (2 * FRAC_BITS + 2) < PROD_W;
    localparam logic [PROD_W-1:0] BOUND =
        BOUND_FITS ? (64'd4 << (2 * FRAC_BITS)) : '0;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic signed [COORD_W-1:0]  zx_reg;
    logic signed [COORD_W-1:0]  zy_reg;
    logic signed [PROD_W-1:0]   xx_reg;
    logic signed [PROD_W-1:0]   yy_reg;
    logic signed [PROD_W-1:0]   xy_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [COUNT_W-1:0]         out_count_reg;

    logic [PROD_W-1:0]          mag;
    logic signed [PROD_W-1:0]   diff;
    logic signed [PROD_W-1:0]   diff_sh;
    logic signed [PROD_W-1:0]   xy_sh;
    logic                       escaped;
    logic                       done;
    logic                       out_free;
    logic                       finish;

    assign mag      = xx_reg + yy_reg;
    assign diff     = xx_reg - yy_reg;
    assign diff_sh  = diff >>> FRAC_BITS;
    // doubling folded into the shift
    assign xy_sh    = xy_reg >>> (FRAC_BITS - 1);
    assign escaped  = BOUND_FITS && (mag >= BOUND);
    assign done     = (count_reg >= cfg.iteration_limit) || escaped;
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign finish   = (state_reg == ST_UPD) && done && out_free;

    assign out_valid    = out_valid_reg;
    assign escape_count = out_count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!done)
                begin
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            zx_reg    <= head.zx;
            zy_reg    <= head.zy;
            count_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            xx_reg <= PROD_W'(zx_reg) * PROD_W'(zx_reg);
            yy_reg <= PROD_W'(zy_reg) * PROD_W'(zy_reg);
            xy_reg <= PROD_W'(zx_reg) * PROD_W'(zy_reg);
        end
        if ((state_reg == ST_UPD) && !done)
        begin
            zx_reg    <= diff_sh[COORD_W-1:0] + cfg.c_real;
            zy_reg    <= xy_sh[COORD_W-1:0] + cfg.c_imag;
            count_reg <= count_reg + 1'b1;
        end
        if (finish)
        begin
            out_count_reg <= count_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/julia_escape_time_core.sv @@
// Flow: the front end registers each pixel's scaled index and pushes the start point
// into the start-point queue, which keeps accepting until full; the iteration engine
// pops it and runs n iterations (at most iteration_limit), each a multiply, then a
// compare and update. The single engine starts a new pixel only once its result is out.
// Reset: asynchronous, clears all control state and queue; registers go to their
// reset values (iteration_limit 512, others 0). No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time_core import jet_pkg::*; #(
    parameter int PIXEL_BITS  = 12,
    parameter int FRAC_BITS   = 28,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIXEL_BITS-1:0] column,
    input  wire logic [PIXEL_BITS-1:0] row,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COUNT_W-1:0]         escape_count,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    jet_cfg_t   cfg_reg;
    jet_point_t push_point;
    jet_point_t head;
    logic       push;
    logic       full;
    logic       pop;
    logic       empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_step          <= '0;
            cfg_reg.x_origin        <= '0;
            cfg_reg.y_step          <= '0;
            cfg_reg.y_origin        <= '0;
            cfg_reg.c_real          <= '0;
            cfg_reg.c_imag          <= '0;
            cfg_reg.iteration_limit <= ITER_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_X_STEP:     cfg_reg.x_step          <= cfg_data;
                REG_X_ORIGIN:   cfg_reg.x_origin        <= cfg_data;
                REG_Y_STEP:     cfg_reg.y_step          <= cfg_data;
                REG_Y_ORIGIN:   cfg_reg.y_origin        <= cfg_data;
                REG_C_REAL:     cfg_reg.c_real          <= cfg_data;
                REG_C_IMAG:     cfg_reg.c_imag          <= cfg_data;
                REG_ITER_LIMIT: cfg_reg.iteration_limit <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    jet_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .column     (column),
        .row        (row),
        .cfg        (cfg_reg),
        .push       (push),
        .push_point (push_point),
        .full       (full)
    );

    jet_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_point (push_point),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    jet_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_count (escape_count)
    );

endmodule

`default_nettype wire

@@ rtl/jet_checker.sv @@
// Port-level checker for the Julia escape-time core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jet_checker import jet_pkg::*; (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [COUNT_W-1:0]    escape_count,
    input wire logic                  cfg_write,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COUNT_W-1:0] limit_reg;
    logic [7:0]         pending_reg;
    logic               in_beat;
    logic               out_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= ITER_LIMIT_RESET;
            pending_reg <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_ITER_LIMIT))
            begin
                limit_reg <= cfg_data[COUNT_W-1:0];
            end
            if (in_beat && !out_beat)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (out_beat && !in_beat)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(escape_count))
        else $error("result beat changed while stalled");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> escape_count <= limit_reg)
        else $error("escape count above iteration limit");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result beat with no pixel outstanding");

endmodule

bind julia_escape_time_core jet_checker u_jet_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .escape_count (escape_count),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for julia_escape_time_core: directed and random pixels against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import jet_pkg::*;

    localparam int PIX_W  = 12;
    localparam int FRAC_W = 28;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam bit ESC_BOUND_OK = (2 * FRAC_W + 2) < 64;
    localparam logic [63:0] ESC_BOUND = ESC_BOUND_OK ? (64'd4 << (2 * FRAC_W)) : 64'd0;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   rw;
        logic [COUNT_W-1:0] count;
    } pixel_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      column = '0;
    logic [PIX_W-1:0]      row = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COUNT_W-1:0]    escape_count;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    jet_cfg_t      shadow_cfg;
    pixel_result_t expected_counts[$];
    int            error_count = 0;
    int unsigned   idle_pct = 0;
    int unsigned   stall_pct = 0;

    julia_escape_time_core #(
        .PIXEL_BITS (PIX_W),
        .FRAC_BITS  (FRAC_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .column       (column),
        .row          (row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_count (escape_count),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(50_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Escape-time count for one pixel under the given register set
    function automatic logic [COUNT_W-1:0] julia_escape_count(input logic [PIX_W-1:0] col,
                                                              input logic [PIX_W-1:0] rw,
                                                              input jet_cfg_t regs);
        logic signed [63:0]        idx_x, idx_y, step_x, step_y, prod_x, prod_y;
        logic signed [63:0]        wx, wy, sq_x, sq_y, prod_xy, diff;
        logic [63:0]               mag;
        logic signed [COORD_W-1:0] zx, zy;
        int unsigned               n;
        idx_x  = {{(64 - PIX_W){1'b0}}, col};
        idx_y  = {{(64 - PIX_W){1'b0}}, rw};
        step_x = $signed(regs.x_step);
        step_y = $signed(regs.y_step);
        prod_x = idx_x * step_x;
        prod_y = idx_y * step_y;
        zx     = prod_x[31:0] - regs.x_origin;
        zy     = prod_y[31:0] - regs.y_origin;
        n      = 0;
        while (n < regs.iteration_limit)
        begin
            wx   = $signed(zx);
            wy   = $signed(zy);
            sq_x = wx * wx;
            sq_y = wy * wy;
            mag  = sq_x + sq_y;
            if (ESC_BOUND_OK && mag >= ESC_BOUND)
                break;
            prod_xy = wx * wy;
            diff    = (sq_x - sq_y) >>> FRAC_W;
            prod_xy = prod_xy >>> (FRAC_W - 1);   // doubling folded into the shift
            zx      = diff[31:0] + regs.c_real;
            zy      = prod_xy[31:0] + regs.c_imag;
            n++;
        end
        return COUNT_W'(n);
    endfunction

    // Result checker and receiver stall generator
    always @(posedge clk)
    begin : result_check
        pixel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_counts.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result: expected none, got escape_count %0d",
                         $time, escape_count);
            end
            else
            begin
                want = expected_counts.pop_front();
                if (escape_count !== want.count)
                begin
                    error_count++;
                    $display("%0t ns: escape_count for pixel (%0d,%0d): expected %0d, got %0d",
                             $time, want.col, want.rw, want.count, escape_count);
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic set_pacing(input int unsigned sender_idle, input int unsigned recv_stall);
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] rw);
        pixel_result_t item;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        column   <= col;
        row      <= rw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        item.col   = col;
        item.rw    = rw;
        item.count = julia_escape_count(col, rw, shadow_cfg);
        expected_counts.push_back(item);
    endtask

    // Sender holds off until every outstanding beat has been checked
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Caller lowers cfg_write after the last write of a burst
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_X_STEP:     shadow_cfg.x_step = data;
            REG_X_ORIGIN:   shadow_cfg.x_origin = data;
            REG_Y_STEP:     shadow_cfg.y_step = data;
            REG_Y_ORIGIN:   shadow_cfg.y_origin = data;
            REG_C_REAL:     shadow_cfg.c_real = data;
            REG_C_IMAG:     shadow_cfg.c_imag = data;
            REG_ITER_LIMIT: shadow_cfg.iteration_limit = data[COUNT_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic write_view(input logic [31:0] xs, input logic [31:0] xo,
                              input logic [31:0] ys, input logic [31:0] yo,
                              input logic [31:0] cr, input logic [31:0] ci,
                              input logic [COUNT_W-1:0] lim);
        wait_until_drained();
        write_reg(REG_X_STEP, xs);
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_Y_STEP, ys);
        write_reg(REG_Y_ORIGIN, yo);
        write_reg(REG_C_REAL, cr);
        write_reg(REG_C_IMAG, ci);
        // upper bits are junk: only the low 16 should land
        write_reg(REG_ITER_LIMIT, {16'($urandom), lim});
        cfg_write <= 1'b0;
    endtask

    task automatic test_reset_values();
        set_pacing(0, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
    endtask

    task automatic test_directed_view();
        set_pacing(18, 18);
        write_view(32'h0003_0000, 32'h1800_0000, 32'h0003_0000, 32'h1800_0000,
                   -32'sd214748365, 32'sd41875931, 16'd100);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd1024, 12'd3000);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
    endtask

    task automatic test_zero_limit();
        set_pacing(0, 60);
        wait_until_drained();
        write_reg(REG_ITER_LIMIT, 32'hFFFF_0000);
        cfg_write <= 1'b0;
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd4095, 12'd17);
    endtask

    task automatic test_unused_register();
        set_pacing(60, 0);
        wait_until_drained();
        write_reg(REG_ITER_LIMIT, 32'd20);
        write_reg(REG_UNUSED, $urandom);
        cfg_write <= 1'b0;
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd1500, 12'd2600);
    endtask

    task automatic test_wraparound();
        set_pacing(0, 0);
        // start point wraps: huge steps, extreme origins
        write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 16'd16);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd1);
        send_pixel(12'd1, 12'd4095);
        // update wraps: small z plus the largest c
        write_view(32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd16);
        send_pixel(12'd384, 12'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd100, 12'd7);
    endtask

    task automatic test_max_limit();
        set_pacing(0, 0);
        write_view(32'h0800_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF);
        send_pixel(12'd0, 12'd0);   // stays at the origin for the full count
        send_pixel(12'd5, 12'd9);
    endtask

    task automatic write_random_view(input logic [COUNT_W-1:0] lim);
        logic signed [31:0] step_x, step_y, pos_x, pos_y, cr, ci;
        int                 centre_x, centre_y;
        step_x   = $urandom_range(32'h0000_1000, 32'h0004_0000);
        step_y   = $urandom_range(32'h0000_1000, 32'h0004_0000);
        if ($urandom_range(1))
            step_x = -step_x;
        if ($urandom_range(1))
            step_y = -step_y;
        pos_x    = int'($urandom_range(0, 3 << 28)) - (3 << 27);
        pos_y    = int'($urandom_range(0, 3 << 28)) - (3 << 27);
        centre_x = $urandom_range(0, 4095);
        centre_y = $urandom_range(0, 4095);
        cr       = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        ci       = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        write_view(step_x, centre_x * step_x - pos_x, step_y, centre_y * step_y - pos_y,
                   cr, ci, lim);
    endtask

    task automatic test_random_views();
        int unsigned        idle_mix[4]  = '{0, 60, 0, 18};
        int unsigned        stall_mix[4] = '{0, 0, 60, 18};
        logic [COUNT_W-1:0] lim;
        for (int phase = 0; phase < 8; phase++)
        begin
            lim = (phase % 4 == 3) ? ITER_LIMIT_RESET : COUNT_W'($urandom_range(1, 48));
            if (phase == 5)
                write_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           COUNT_W'($urandom_range(0, 64)));
            else
                write_random_view(lim);
            set_pacing(idle_mix[phase % 4], stall_mix[phase % 4]);
            repeat (144)
                send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
        end
    endtask

    initial
    begin
        shadow_cfg                 = '0;
        shadow_cfg.iteration_limit = ITER_LIMIT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_view();
        test_zero_limit();
        test_unused_register();
        test_wraparound();
        test_max_limit();
        test_random_views();
        wait_until_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
